>>> hw/rtl/mwpo_pkg.sv
// package: widths, codes, payload types and sine table builder for the oscillator
package mwpo_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int SINE_TABLE_BITS = 10;
	localparam int SINE_N          = 1 << SINE_TABLE_BITS;

	localparam int PHASE_W   = 32;
	localparam int STEP_W    = 31;
	localparam int GAIN_W    = 16;
	localparam int WAVE_SEL_W = 2;
	localparam int MIX_W     = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 31;

	localparam int WAVE_W  = SAMPLE_BITS + 1;
	localparam int TRI_W   = SAMPLE_BITS + 2;
	localparam int PROD_W  = WAVE_W + GAIN_W + 1;
	localparam int ROUND_SHIFT = 15;
	localparam int LEVEL_W = PROD_W - ROUND_SHIFT;
	localparam int SUM_W   = LEVEL_W + 1;

	localparam longint FULL_SCALE = longint'(1) << (SAMPLE_BITS - 1);

	localparam logic signed [WAVE_W-1:0] WAVE_FS  = {2'b01, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [TRI_W-1:0]  TRI_FS   = {3'b001, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [TRI_W-1:0]  TRI_3FS  = {3'b011, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]  SAT_MAX  = SUM_W'(FULL_SCALE - 1);
	localparam logic signed [SUM_W-1:0]  SAT_MIN  = -SUM_W'(FULL_SCALE);
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

	localparam logic [STEP_W-1:0]     RST_PHASE_STEP = STEP_W'(39370534);
	localparam logic [GAIN_W-1:0]     RST_GAIN_LEVEL = GAIN_W'(16384);
	localparam logic [WAVE_SEL_W-1:0] RST_WAVEFORM   = '0;
	localparam logic [MIX_W-1:0]      RST_MIXED      = '0;

	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_LEVEL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIXED      = 2'd3;

	localparam logic [WAVE_SEL_W-1:0] WAVE_SINE     = 2'd0;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SAW      = 2'd1;
	localparam logic [WAVE_SEL_W-1:0] WAVE_SQUARE   = 2'd2;
	localparam logic [WAVE_SEL_W-1:0] WAVE_TRIANGLE = 2'd3;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_left;
		logic signed [SAMPLE_BITS-1:0] in_right;
	} in_frame_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
	} out_frame_t;

	typedef struct packed {
		logic                     is_sine;
		logic                     neg;
		logic signed [WAVE_W-1:0] level;
	} wave_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	typedef logic [SAMPLE_BITS-1:0] sine_rom_t [0:SINE_N];

	// quarter-wave magnitudes already scaled to full scale with rounding
	function automatic sine_rom_t sine_rom_build();
		sine_rom_t   rom;
		logic [63:0] a;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] mag;
		for (int j = 0; j <= SINE_N; j++) begin
			a = (64'(j) * HALF_PI_Q30) >> SINE_TABLE_BITS;
			sum = a;
			term = a;
			for (int n = 1; n <= 7; n++) begin
				term = (term * a) >> 30;
				term = (term * a) >> 30;
				term = term / 64'(TAYLOR_DIV[n]);
				if ((n & 1) == 1) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			if (sum > ONE_Q30) begin
				sum = ONE_Q30;
			end
			mag = (sum * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
			rom[j] = mag[SAMPLE_BITS-1:0];
		end
		return rom;
	endfunction

endpackage

>>> hw/rtl/mwpo_wave.sv
// phase accumulator, waveform shaping and registered sine table read
module mwpo_wave (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                load,
	input  logic [mwpo_pkg::STEP_W-1:0]         phase_step,
	input  logic [mwpo_pkg::WAVE_SEL_W-1:0]     waveform,
	output mwpo_pkg::wave_t                     wave_s1,
	output logic [mwpo_pkg::SAMPLE_BITS-1:0]    sine_mag_s1
);

	localparam mwpo_pkg::sine_rom_t SINE_ROM = mwpo_pkg::sine_rom_build();

	logic [mwpo_pkg::PHASE_W-1:0]            phase_q;
	logic [1:0]                              quadrant;
	logic [mwpo_pkg::SINE_TABLE_BITS-1:0]    k;
	logic [mwpo_pkg::SINE_TABLE_BITS:0]      j;
	logic [63:0]                             scaled;
	logic [mwpo_pkg::SAMPLE_BITS-1:0]        saw_raw;
	logic [mwpo_pkg::SAMPLE_BITS:0]          tri_raw;
	logic signed [mwpo_pkg::TRI_W-1:0]       tri_val;
	logic signed [mwpo_pkg::WAVE_W-1:0]      level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= phase_q + {1'b0, phase_step};
		end
	end

	always_comb begin
		quadrant = phase_q[31:30];
		k = phase_q[29 -: mwpo_pkg::SINE_TABLE_BITS];
		j = quadrant[0] ? ((mwpo_pkg::SINE_TABLE_BITS+1)'(mwpo_pkg::SINE_N) - {1'b0, k})
		                : {1'b0, k};
		scaled = {32'd0, phase_q} << mwpo_pkg::SAMPLE_BITS;
		saw_raw = scaled[31+mwpo_pkg::SAMPLE_BITS:32];
		tri_raw = scaled[31+mwpo_pkg::SAMPLE_BITS:31];
		if (!phase_q[31]) begin
			tri_val = $signed({1'b0, tri_raw}) - mwpo_pkg::TRI_FS;
		end else begin
			tri_val = mwpo_pkg::TRI_3FS - $signed({1'b0, tri_raw});
		end
		case (waveform)
			mwpo_pkg::WAVE_SAW: begin
				level = $signed({1'b0, saw_raw}) - mwpo_pkg::WAVE_FS;
			end
			mwpo_pkg::WAVE_SQUARE: begin
				level = (phase_q != '0 && !phase_q[31]) ? mwpo_pkg::WAVE_FS
				                                         : -mwpo_pkg::WAVE_FS;
			end
			mwpo_pkg::WAVE_TRIANGLE: begin
				level = tri_val[mwpo_pkg::WAVE_W-1:0];
			end
			default: begin
				level = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wave_s1.is_sine <= (waveform == mwpo_pkg::WAVE_SINE);
			wave_s1.neg     <= quadrant[1];
			wave_s1.level   <= level;
			sine_mag_s1     <= SINE_ROM[j];
		end
	end

endmodule

>>> hw/rtl/mwpo_gain.sv
// signed waveform value times unsigned gain, product registered
module mwpo_gain (
	input  logic                                   clk,
	input  logic                                   load,
	input  mwpo_pkg::wave_t                        wave_s1,
	input  logic [mwpo_pkg::SAMPLE_BITS-1:0]       sine_mag_s1,
	input  logic [mwpo_pkg::GAIN_W-1:0]            gain_level,
	output logic signed [mwpo_pkg::PROD_W-1:0]     prod_s2
);

	logic signed [mwpo_pkg::WAVE_W-1:0] mag;
	logic signed [mwpo_pkg::WAVE_W-1:0] w;
	logic signed [mwpo_pkg::GAIN_W:0]   gain_s;

	always_comb begin
		mag = $signed({1'b0, sine_mag_s1});
		if (wave_s1.is_sine) begin
			w = wave_s1.neg ? -mag : mag;
		end else begin
			w = wave_s1.level;
		end
		gain_s = $signed({1'b0, gain_level});
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= mwpo_pkg::PROD_W'(w) * mwpo_pkg::PROD_W'(gain_s);
		end
	end

endmodule

>>> hw/rtl/mwpo_lane.sv
// one channel: round the gained value, optional input mix, saturate
module mwpo_lane (
	input  logic                                   clk,
	input  logic                                   load,
	input  logic signed [mwpo_pkg::PROD_W-1:0]     prod_s2,
	input  logic signed [mwpo_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   mix,
	output logic signed [mwpo_pkg::SAMPLE_BITS-1:0] result_s3
);

	logic signed [mwpo_pkg::PROD_W-1:0]  rounded;
	logic signed [mwpo_pkg::LEVEL_W-1:0] g;
	logic signed [mwpo_pkg::SUM_W-1:0]   addend;
	logic signed [mwpo_pkg::SUM_W-1:0]   sum;
	logic signed [mwpo_pkg::SAMPLE_BITS-1:0] sat;

	always_comb begin
		rounded = prod_s2 + mwpo_pkg::ROUND_HALF;
		g = rounded[mwpo_pkg::PROD_W-1:mwpo_pkg::ROUND_SHIFT];
		addend = mix ? mwpo_pkg::SUM_W'(sample) : '0;
		sum = mwpo_pkg::SUM_W'(g) + addend;
		if (sum > mwpo_pkg::SAT_MAX) begin
			sat = mwpo_pkg::SAT_MAX[mwpo_pkg::SAMPLE_BITS-1:0];
		end else if (sum < mwpo_pkg::SAT_MIN) begin
			sat = mwpo_pkg::SAT_MIN[mwpo_pkg::SAMPLE_BITS-1:0];
		end else begin
			sat = sum[mwpo_pkg::SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s3 <= sat;
		end
	end

endmodule

>>> hw/rtl/multi_waveform_phase_oscillator_top.sv
// top level: config registers, pipeline control, wave, gain, two channel lanes, output merge
// an accepted transaction passes the s1, s2 and s3 stage registers on its way to out_valid
// throughput: one stereo frame per cycle while the output is not stalled, limited by the single phase add loop
// the sine table is a constant rom read through one registered port
// reset clears the phase accumulator and all stage valids, registers return to defaults
module multi_waveform_phase_oscillator_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  mwpo_pkg::in_frame_t                   in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output mwpo_pkg::out_frame_t                  out_data,
	input  logic                                  cfg_we,
	input  logic [mwpo_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mwpo_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [mwpo_pkg::STEP_W-1:0]     phase_step_q;
	logic [mwpo_pkg::GAIN_W-1:0]     gain_level_q;
	logic [mwpo_pkg::WAVE_SEL_W-1:0] waveform_q;
	logic [mwpo_pkg::MIX_W-1:0]      mixed_q;

	logic                            valid_s1;
	logic                            valid_s2;
	logic                            valid_s3;
	mwpo_pkg::stage_en_t             en;
	logic                            accept;

	mwpo_pkg::in_frame_t             in_s1;
	mwpo_pkg::in_frame_t             in_s2;
	mwpo_pkg::wave_t                 wave_s1;
	logic [mwpo_pkg::SAMPLE_BITS-1:0] sine_mag_s1;
	logic signed [mwpo_pkg::PROD_W-1:0] prod_s2;
	logic signed [mwpo_pkg::SAMPLE_BITS-1:0] left_s3;
	logic signed [mwpo_pkg::SAMPLE_BITS-1:0] right_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= mwpo_pkg::RST_PHASE_STEP;
			gain_level_q <= mwpo_pkg::RST_GAIN_LEVEL;
			waveform_q   <= mwpo_pkg::RST_WAVEFORM;
			mixed_q      <= mwpo_pkg::RST_MIXED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mwpo_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
				mwpo_pkg::REG_GAIN_LEVEL: gain_level_q <= cfg_data[mwpo_pkg::GAIN_W-1:0];
				mwpo_pkg::REG_WAVEFORM:   waveform_q   <= cfg_data[mwpo_pkg::WAVE_SEL_W-1:0];
				mwpo_pkg::REG_MIXED:      mixed_q      <= cfg_data[mwpo_pkg::MIX_W-1:0];
			endcase
		end
	end

	// each stage loads when empty or when the one after it moves
	always_comb begin
		en.s3 = !valid_s3 || !out_stall;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
		in_stall = !en.s1;
		accept = in_valid && en.s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= in_valid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			in_s1 <= in_data;
		end
		if (en.s2) begin
			in_s2 <= in_s1;
		end
	end

	mwpo_wave u_wave (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.load        (en.s1),
		.phase_step  (phase_step_q),
		.waveform    (waveform_q),
		.wave_s1     (wave_s1),
		.sine_mag_s1 (sine_mag_s1)
	);

	mwpo_gain u_gain (
		.clk         (clk),
		.load        (en.s2),
		.wave_s1     (wave_s1),
		.sine_mag_s1 (sine_mag_s1),
		.gain_level  (gain_level_q),
		.prod_s2     (prod_s2)
	);

	mwpo_lane u_lane_left (
		.clk       (clk),
		.load      (en.s3),
		.prod_s2   (prod_s2),
		.sample    (in_s2.in_left),
		.mix       (mixed_q != '0),
		.result_s3 (left_s3)
	);

	mwpo_lane u_lane_right (
		.clk       (clk),
		.load      (en.s3),
		.prod_s2   (prod_s2),
		.sample    (in_s2.in_right),
		.mix       (mixed_q[1]),
		.result_s3 (right_s3)
	);

	// merge the lanes into one output transaction
	always_comb begin
		out_data.out_left  = left_s3;
		out_data.out_right = right_s3;
		out_valid = valid_s3;
	end

endmodule

>>> hw/rtl/mwpo_checker.sv
// port-level checker for the oscillator top, attached by bind
module mwpo_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input mwpo_pkg::out_frame_t              out_data
);

	// nothing comes out while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// input is only held back when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output");

	// a new result must match an earlier accepted input transaction
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 3))
		else $error("result without a matching input transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled output changed");

endmodule

bind multi_waveform_phase_oscillator_top mwpo_checker u_mwpo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/tb_multi_waveform_phase_oscillator_top.sv
// testbench for the oscillator top: random frames and settings checked against a bit-exact predictor
module tb_multi_waveform_phase_oscillator_top;
	import mwpo_pkg::*;

	typedef longint unsigned u64_t;

	localparam int HOLD_CYCLES = 200;
	localparam int LATENCY     = 3;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	in_frame_t              in_data;
	logic                   out_valid;
	logic                   out_stall;
	out_frame_t             out_data;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [PHASE_W-1:0]    osc_phase = '0;
	logic [STEP_W-1:0]     osc_step  = RST_PHASE_STEP;
	logic [GAIN_W-1:0]     osc_gain  = RST_GAIN_LEVEL;
	logic [WAVE_SEL_W-1:0] osc_wave  = RST_WAVEFORM;
	logic [MIX_W-1:0]      osc_mix   = RST_MIXED;

	out_frame_t expected_frames[$];
	out_frame_t due_frame;
	int         mismatch_count = 0;
	int         send_gap_pct   = 0;
	int         recv_stall_pct = 0;
	bit         hold_request   = 1'b0;

	multi_waveform_phase_oscillator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// quarter-wave sine in Q30 by truncated taylor series
	function automatic u64_t sine_q30(int unsigned j);
		u64_t angle;
		u64_t acc;
		u64_t term;
		angle = (u64_t'(j) * HALF_PI_Q30) >> SINE_TABLE_BITS;
		acc = angle;
		term = angle;
		for (int n = 1; n <= 7; n++) begin
			term = (term * angle) >> 30;
			term = (term * angle) >> 30;
			term = term / u64_t'(2 * n * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = (acc >= term) ? acc - term : 0;
			end else begin
				acc = acc + term;
			end
		end
		return (acc > ONE_Q30) ? ONE_Q30 : acc;
	endfunction

	function automatic longint wave_level(logic [PHASE_W-1:0] ph);
		u64_t        scaled;
		int unsigned k;
		int unsigned j;
		longint      mag;
		scaled = u64_t'(ph) << SAMPLE_BITS;
		case (osc_wave)
			WAVE_SAW: begin
				return longint'(scaled >> PHASE_W) - FULL_SCALE;
			end
			WAVE_SQUARE: begin
				return (ph != '0 && !ph[PHASE_W-1]) ? FULL_SCALE : -FULL_SCALE;
			end
			WAVE_TRIANGLE: begin
				mag = longint'(scaled >> (PHASE_W - 1));
				return ph[PHASE_W-1] ? 3 * FULL_SCALE - mag : mag - FULL_SCALE;
			end
			default: begin
				k = ph[PHASE_W-3 -: SINE_TABLE_BITS];
				j = ph[PHASE_W-2] ? SINE_N - k : k;
				mag = longint'((sine_q30(j) * u64_t'(FULL_SCALE) + (u64_t'(1) << 29)) >> 30);
				return ph[PHASE_W-1] ? -mag : mag;
			end
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(longint v);
		if (v > FULL_SCALE - 1) begin
			return SAMPLE_BITS'(FULL_SCALE - 1);
		end
		if (v < -FULL_SCALE) begin
			return SAMPLE_BITS'(-FULL_SCALE);
		end
		return SAMPLE_BITS'(v);
	endfunction

	// output frame for the current phase, then the phase advances
	function automatic out_frame_t synth_frame(in_frame_t f);
		out_frame_t r;
		longint     level;
		level = (wave_level(osc_phase) * longint'(osc_gain)
			+ (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		r.out_left  = clamp_sample(level + ((osc_mix >= 1) ? longint'(f.in_left) : 64'sd0));
		r.out_right = clamp_sample(level + ((osc_mix >= 2) ? longint'(f.in_right) : 64'sd0));
		osc_phase = osc_phase + PHASE_W'(osc_step);
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] edge_sample(int i);
		case (i % 4)
			0: return SAMPLE_BITS'(-FULL_SCALE);
			1: return SAMPLE_BITS'(FULL_SCALE - 1);
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick < 4) begin
			return edge_sample(pick);
		end
		return SAMPLE_BITS'($urandom);
	endfunction

	function automatic in_frame_t random_frame();
		in_frame_t f;
		f.in_left  = random_sample();
		f.in_right = random_sample();
		return f;
	endfunction

	// output side: random stall bursts, or one long hold when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < recv_stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				$display("%0t unexpected transaction: expected none, actual %h", $time, out_data);
				mismatch_count++;
			end else begin
				due_frame = expected_frames.pop_front();
				if (out_data.out_left !== due_frame.out_left) begin
					$display("%0t out_left mismatch: expected %0d, actual %0d",
						$time, due_frame.out_left, out_data.out_left);
					mismatch_count++;
				end
				if (out_data.out_right !== due_frame.out_right) begin
					$display("%0t out_right mismatch: expected %0d, actual %0d",
						$time, due_frame.out_right, out_data.out_right);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_frame(input in_frame_t f);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= f;
		do begin
			@(posedge clk);
		end while (in_stall);
		expected_frames.push_back(synth_frame(f));
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) begin
			@(negedge clk);
		end
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_PHASE_STEP: osc_step = val[STEP_W-1:0];
			REG_GAIN_LEVEL: osc_gain = val[GAIN_W-1:0];
			REG_WAVEFORM:   osc_wave = val[WAVE_SEL_W-1:0];
			REG_MIXED:      osc_mix  = val[MIX_W-1:0];
		endcase
		@(negedge clk);
	endtask

	task automatic apply_settings(input logic [STEP_W-1:0] step, input logic [GAIN_W-1:0] gain,
		input logic [WAVE_SEL_W-1:0] wave, input logic [MIX_W-1:0] mix);
		settle();
		write_reg(REG_PHASE_STEP, CFG_DATA_W'(step));
		write_reg(REG_GAIN_LEVEL, CFG_DATA_W'(gain));
		write_reg(REG_WAVEFORM, CFG_DATA_W'(wave));
		write_reg(REG_MIXED, CFG_DATA_W'(mix));
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		in_frame_t f;
		f.in_left  = edge_sample(0);
		f.in_right = edge_sample(1);
		send_frame(f);
		f.in_left  = edge_sample(1);
		f.in_right = edge_sample(0);
		send_frame(f);
	endtask

	task automatic test_sine_quadrants();
		logic [PHASE_W-1:0] delta;
		logic [STEP_W-1:0]  piece;
		in_frame_t          f;
		// steer the phase onto the quarter-cycle point
		delta = (PHASE_W'(1) << 30) - osc_phase;
		for (int i = 0; i < 3; i++) begin
			piece = STEP_W'((i < 2) ? delta / 3 : delta - 2 * (delta / 3));
			apply_settings(piece, RST_GAIN_LEVEL, WAVE_SINE, 0);
			send_frame(random_frame());
		end
		// unity gain peak, right channel pure synthesis
		apply_settings(STEP_W'(1) << 29, GAIN_W'(32768), WAVE_SINE, 1);
		for (int i = 0; i < 8; i++) begin
			f.in_left  = edge_sample(i);
			f.in_right = edge_sample(i + 1);
			send_frame(f);
		end
	endtask

	task automatic test_other_waveforms();
		in_frame_t f;
		// mixed count three with gain above one
		apply_settings(STEP_W'(1) << 30, '1, WAVE_SQUARE, 3);
		for (int i = 0; i < 4; i++) begin
			f.in_left  = edge_sample(i);
			f.in_right = edge_sample(3 - i);
			send_frame(f);
		end
		apply_settings(STEP_W'(1) << 30, GAIN_W'(32768), WAVE_TRIANGLE, 0);
		for (int i = 0; i < 4; i++) begin
			send_frame(random_frame());
		end
		apply_settings('1, GAIN_W'(12345), WAVE_SAW, 2);
		for (int i = 0; i < 4; i++) begin
			f.in_left  = edge_sample(i + 2);
			f.in_right = edge_sample(i);
			send_frame(f);
		end
	endtask

	task automatic test_random_settings(input int phases);
		logic [STEP_W-1:0] step;
		logic [GAIN_W-1:0] gain;
		int                count;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 4))
				0: step = '0;
				1: step = '1;
				2: step = STEP_W'($urandom_range(1, 65536));
				default: step = STEP_W'($urandom);
			endcase
			case ($urandom_range(0, 4))
				0: gain = '0;
				1: gain = GAIN_W'(32768);
				2: gain = '1;
				default: gain = GAIN_W'($urandom);
			endcase
			send_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			recv_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 15);
			apply_settings(step, gain, WAVE_SEL_W'($urandom), MIX_W'($urandom));
			count = $urandom_range(60, 140);
			repeat (count) send_frame(random_frame());
		end
	endtask

	task automatic test_backpressure();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b1;
		repeat (40) send_frame(random_frame());
		settle();
		send_gap_pct   = 20;
		recv_stall_pct = 10;
		repeat (40) send_frame(random_frame());
	endtask

	task automatic test_steady_stream();
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		apply_settings(STEP_W'($urandom), GAIN_W'($urandom), WAVE_SEL_W'($urandom),
			MIX_W'($urandom));
		repeat (150) send_frame(random_frame());
	endtask

	initial begin
		arst_n    = 1'b1;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		// a real falling edge so the asynchronous reset acts before the first clock
		#1;
		arst_n    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_gap_pct   = 15;
		recv_stall_pct = 5;
		test_reset_defaults();
		test_sine_quadrants();
		test_other_waveforms();
		test_random_settings(16);
		test_backpressure();
		test_steady_stream();
		settle();
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(12 * 1000000);
		$display("FAILURE");
		$finish;
	end

endmodule
